FILE: src/lfs_pkg.sv
// Shared types, constants and lookup functions for the line-follow steering block.
// No dependencies; every other file of the block imports this package.
package lfs_pkg;

    // Field and datapath widths
    localparam int SENSORS   = 8;
    localparam int IDX_W     = 3;
    localparam int SERVO_W   = 11;
    localparam int SPAN_W    = SERVO_W + 1;
    localparam int OPND_W    = 16;
    localparam int GAIN_W    = OPND_W;
    localparam int DUTY_W    = 8;
    localparam int POS_W     = 12;
    localparam int WSUM_W    = 16;
    localparam int CNT_W     = 4;
    localparam int SPEED_W   = 9;
    localparam int SPEEDC_W  = 7;
    localparam int DVSR_W    = 5;

    // Bus widths
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;
    localparam int SDATA_W   = 8;
    localparam int MFIELD_W  = SERVO_W + DUTY_W + 1 + 1 + POS_W;
    localparam int MDATA_W   = 40;
    localparam int MPAD_W    = MDATA_W - MFIELD_W;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_CENTER     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LEFT       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_P     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_TURN_SPEED = 3'd7;

    // Sensor weight fractions
    localparam logic [1:0] PCT_FULL    = 2'd0;
    localparam logic [1:0] PCT_3QUART  = 2'd1;
    localparam logic [1:0] PCT_1QUART  = 2'd2;
    localparam logic [1:0] PCT_TENTH   = 2'd3;

    // Shared unit operations
    localparam logic ALU_OP_MUL = 1'b0;
    localparam logic ALU_OP_DIV = 1'b1;

    // Run-length rules
    localparam logic [CNT_W-1:0]  MAX_RUN_CNT       = 4'd4;
    localparam logic [DVSR_W-1:0] SPEED_DIV_DARK    = 5'd10;
    localparam logic [DVSR_W-1:0] POS_DIV_DARK      = 5'd2;

    typedef struct packed {
        logic [SERVO_W-1:0] center_position;
        logic [SERVO_W-1:0] right_limit;
        logic [SERVO_W-1:0] left_limit;
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [DUTY_W-1:0]  max_speed;
        logic [DUTY_W-1:0]  turn_speed;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        center_position: 11'd96,
        right_limit:     11'd76,
        left_limit:      11'd116,
        gain_p:          16'd205,
        gain_i:          16'd0,
        gain_d:          16'd0,
        max_speed:       8'd85,
        turn_speed:      8'd85
    };

    typedef struct packed {
        logic start;
        logic op;
        logic clr;
    } alu_cmd_t;

    function automatic logic [1:0] sensor_pct_code(input logic [IDX_W-1:0] idx);
        logic [1:0] code;
        case (idx)
            3'd0, 3'd7: code = PCT_FULL;
            3'd1, 3'd6: code = PCT_3QUART;
            3'd2, 3'd5: code = PCT_1QUART;
            default:    code = PCT_TENTH;
        endcase
        return code;
    endfunction

    function automatic logic [SPEEDC_W-1:0] sensor_speed(input logic [IDX_W-1:0] idx);
        logic [SPEEDC_W-1:0] spd;
        case (idx)
            3'd0, 3'd1, 3'd6, 3'd7: spd = 7'd90;
            3'd2, 3'd5:             spd = 7'd30;
            default:                spd = 7'd5;
        endcase
        return spd;
    endfunction

endpackage

FILE: src/lfs_cfg.sv
// APB-style configuration register file for the line-follow steering block.
// Depends on lfs_pkg for the register map, reset values and cfg_t.
module lfs_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfs_pkg::PADDR_W-1:0] paddr,
    input  logic [lfs_pkg::PDATA_W-1:0] pwdata,
    output logic [lfs_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output lfs_pkg::cfg_t               cfg
);
    import lfs_pkg::*;

    cfg_t                 cfg_reg, cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_CENTER:     cfg_next.center_position = pwdata[SERVO_W-1:0];
                REG_RIGHT:      cfg_next.right_limit     = pwdata[SERVO_W-1:0];
                REG_LEFT:       cfg_next.left_limit      = pwdata[SERVO_W-1:0];
                REG_GAIN_P:     cfg_next.gain_p          = pwdata[GAIN_W-1:0];
                REG_GAIN_I:     cfg_next.gain_i          = pwdata[GAIN_W-1:0];
                REG_GAIN_D:     cfg_next.gain_d          = pwdata[GAIN_W-1:0];
                REG_MAX_SPEED:  cfg_next.max_speed       = pwdata[DUTY_W-1:0];
                REG_TURN_SPEED: cfg_next.turn_speed      = pwdata[DUTY_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CENTER:     prdata = PDATA_W'(cfg_reg.center_position);
            REG_RIGHT:      prdata = PDATA_W'(cfg_reg.right_limit);
            REG_LEFT:       prdata = PDATA_W'(cfg_reg.left_limit);
            REG_GAIN_P:     prdata = PDATA_W'(cfg_reg.gain_p);
            REG_GAIN_I:     prdata = PDATA_W'(cfg_reg.gain_i);
            REG_GAIN_D:     prdata = PDATA_W'(cfg_reg.gain_d);
            REG_MAX_SPEED:  prdata = PDATA_W'(cfg_reg.max_speed);
            REG_TURN_SPEED: prdata = PDATA_W'(cfg_reg.turn_speed);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: src/lfs_weight.sv
// Per-sensor weight term: a fixed fraction of the steering span, truncated toward zero.
// Depends on lfs_pkg for widths and the sensor fraction table.
module lfs_weight (
    input  logic signed [lfs_pkg::SPAN_W-1:0] span,
    input  logic        [lfs_pkg::IDX_W-1:0]  idx,
    output logic signed [lfs_pkg::SPAN_W-1:0] term
);
    import lfs_pkg::*;

    localparam int MAG_W       = SPAN_W - 1;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    // 6554 / 65536 is exact floor(m / 10) for every m below 2048
    localparam logic [RECIP_W-1:0] RECIP_TENTH = 13'd6554;

    logic                       neg;
    logic [SPAN_W-1:0]          abs_span;
    logic [MAG_W-1:0]           mag;
    logic [MAG_W+1:0]           triple;
    logic [MAG_W+RECIP_W-1:0]   tenth_prod;
    logic [MAG_W+RECIP_W-1:0]   tenth_shift;
    logic [MAG_W-1:0]           res;

    assign neg         = span[SPAN_W-1];
    assign abs_span    = neg ? -span : span;
    assign mag         = abs_span[MAG_W-1:0];
    assign triple      = {2'b00, mag} + {1'b0, mag, 1'b0};
    assign tenth_prod  = mag * RECIP_TENTH;
    assign tenth_shift = tenth_prod >> RECIP_SHIFT;

    always_comb begin
        case (sensor_pct_code(idx))
            PCT_FULL:   res = mag;
            PCT_3QUART: res = triple[MAG_W+1:2];
            PCT_1QUART: res = mag >> 2;
            PCT_TENTH:  res = tenth_shift[MAG_W-1:0];
            default:    res = mag;
        endcase
    end

    assign term = neg ? -$signed({1'b0, res}) : $signed({1'b0, res});

endmodule

FILE: src/lfs_alu.sv
// Shared iterative unit: shift-add multiply-accumulate and restoring division,
// both running on one adder. Depends on lfs_pkg for operand widths and alu_cmd_t.
module lfs_alu #(
    parameter int ACC_W = 50
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lfs_pkg::alu_cmd_t           cmd,
    input  logic signed [ACC_W-1:0]     mul_cand,
    input  logic [lfs_pkg::OPND_W-1:0]  mul_plier,
    input  logic [lfs_pkg::OPND_W-1:0]  div_dend,
    input  logic [lfs_pkg::DVSR_W-1:0]  div_sor,
    output logic                        busy,
    output logic signed [ACC_W-1:0]     acc,
    output logic [lfs_pkg::OPND_W-1:0]  quot
);
    import lfs_pkg::*;

    localparam int STEP_W = $clog2(OPND_W);

    logic              busy_reg, busy_next;
    logic              op_reg, op_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  mcand_reg, mcand_next;
    logic [OPND_W-1:0] shf_reg, shf_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    logic [DVSR_W:0]   rem_shift;
    logic [ACC_W-1:0]  rem_ext;
    logic [ACC_W-1:0]  add_a, add_b, add_sum;
    logic              add_cin;
    logic              trial_neg;

    // Remainder shifted left with the next dividend bit
    assign rem_shift = {acc_reg[DVSR_W-1:0], shf_reg[OPND_W-1]};
    assign rem_ext   = {{(ACC_W-DVSR_W-1){1'b0}}, rem_shift};

    always_comb begin
        if (op_reg == ALU_OP_DIV) begin
            add_a   = rem_ext;
            add_b   = ~mcand_reg;
            add_cin = 1'b1;
        end else begin
            add_a   = acc_reg;
            add_b   = shf_reg[0] ? mcand_reg : '0;
            add_cin = 1'b0;
        end
    end

    assign add_sum   = add_a + add_b + ACC_W'(add_cin);
    assign trial_neg = add_sum[ACC_W-1];

    always_comb begin
        busy_next  = busy_reg;
        op_next    = op_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        shf_next   = shf_reg;
        cnt_next   = cnt_reg;
        if (cmd.start) begin
            op_next  = cmd.op;
            cnt_next = '0;
            if (cmd.op == ALU_OP_DIV) begin
                acc_next   = '0;
                mcand_next = {{(ACC_W-DVSR_W){1'b0}}, div_sor};
                shf_next   = div_dend;
                busy_next  = 1'b1;
            end else begin
                if (cmd.clr) begin
                    acc_next = '0;
                end
                mcand_next = mul_cand;
                shf_next   = mul_plier;
                busy_next  = (mul_plier != '0);
            end
        end else if (busy_reg) begin
            if (op_reg == ALU_OP_DIV) begin
                acc_next = trial_neg ? rem_ext : add_sum;
                shf_next = {shf_reg[OPND_W-2:0], ~trial_neg};
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(OPND_W - 1)) begin
                    busy_next = 1'b0;
                end
            end else begin
                acc_next   = add_sum;
                mcand_next = mcand_reg << 1;
                shf_next   = shf_reg >> 1;
                // stop once no multiplier bits remain
                busy_next  = (shf_reg[OPND_W-1:1] != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        op_reg    <= op_next;
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        shf_reg   <= shf_next;
        cnt_reg   <= cnt_next;
    end

    assign busy = busy_reg;
    assign acc  = $signed(acc_reg);
    assign quot = shf_reg;

endmodule

FILE: src/line_follow_steering_top.sv
// Line-follow steering top: sensor scan, position filter, PID and motor duty.
// Each sample runs an eight-sensor scan and one or two 16-step divisions (position, then
// speed unless the sample is a glitch); off the edge-turn path the PID adds three shift-add
// multiplies of up to 16 steps each; the divisions and multiplies share one unit.
// One sample is in work at a time; input is taken again once the result enters the result register.
// Reset (synchronous, aresetn low) clears the filter and PID state and loads default config.
module line_follow_steering_top #(
    parameter int GAIN_FRACTION_BITS = 8,
    parameter int INTEGRAL_BITS      = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfs_pkg::PADDR_W-1:0] paddr,
    input  logic [lfs_pkg::PDATA_W-1:0] pwdata,
    output logic [lfs_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [lfs_pkg::SDATA_W-1:0] s_axis_tdata,   // [7:0] sensor_bits
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [10:0] servo_compare, [18:11] motor_duty, [19] brake_pulse, [20] edge_turn,
    // [32:21] line_position, [39:33] zero
    output logic [lfs_pkg::MDATA_W-1:0] m_axis_tdata
);
    import lfs_pkg::*;

    localparam int ACC_W = INTEGRAL_BITS + OPND_W + 2;
    localparam int I_W   = INTEGRAL_BITS;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_SCAN      = 4'd1;
    localparam logic [3:0] ST_PREP      = 4'd2;
    localparam logic [3:0] ST_DIVP_GO   = 4'd3;
    localparam logic [3:0] ST_DIVP_WAIT = 4'd4;
    localparam logic [3:0] ST_DIVS_WAIT = 4'd5;
    localparam logic [3:0] ST_INTEG     = 4'd6;
    localparam logic [3:0] ST_MULP      = 4'd7;
    localparam logic [3:0] ST_MULI      = 4'd8;
    localparam logic [3:0] ST_MULD      = 4'd9;
    localparam logic [3:0] ST_FIN_A     = 4'd10;
    localparam logic [3:0] ST_FIN_B     = 4'd11;
    localparam logic [3:0] ST_FINISH    = 4'd12;

    cfg_t cfg;

    logic [3:0]                state_reg, state_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [SDATA_W-1:0]        bits_reg, bits_next;
    logic signed [WSUM_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [SPEED_W-1:0]        speed_reg, speed_next;
    logic                      edge_reg, edge_next;
    logic                      glitch_reg, glitch_next;
    logic                      neg_reg, neg_next;
    logic signed [POS_W-1:0]   pos_reg, pos_next;
    logic signed [WSUM_W-1:0]  prev_sum_reg, prev_sum_next;
    logic [CNT_W-1:0]          prev_cnt_reg, prev_cnt_next;
    logic [SPEED_W-1:0]        prev_speed_reg, prev_speed_next;
    logic [DUTY_W-1:0]         spa_reg, spa_next;
    logic signed [POS_W-1:0]   last_pos_reg, last_pos_next;
    logic signed [I_W-1:0]     integ_reg, integ_next;
    logic [ACC_W-1:0]          mag_reg, mag_next;
    logic signed [ACC_W:0]     wide_reg, wide_next;
    logic                      m_valid_reg, m_valid_next;
    logic [MDATA_W-1:0]        m_data_reg, m_data_next;

    // Scan datapath
    logic signed [SPAN_W-1:0]  rspan, lspan, span_sel, term;
    logic [SPEEDC_W-1:0]       spd_c;

    // Position division setup
    logic                      glitch;
    logic signed [WSUM_W:0]    num_run, num;
    logic [WSUM_W:0]           num_abs;
    logic [DVSR_W-1:0]         sor_pos, sor_spd;
    logic signed [POS_W-1:0]   pos_q;
    logic [DUTY_W:0]           spa_sum;

    // PID and output
    logic [I_W:0]              isum;
    logic signed [POS_W:0]     pos_diff;
    logic [ACC_W-1:0]          acc_abs;
    logic [ACC_W:0]            center_w, mag_w;
    logic [SERVO_W-1:0]        lo, hi, servo_pid, servo_edge, servo;
    logic signed [ACC_W:0]     lo_w, hi_w;
    logic [SPAN_W:0]           e_sum;
    logic [DUTY_W-1:0]         duty;
    logic                      brake;

    // Shared unit
    alu_cmd_t                  alu_cmd;
    logic signed [ACC_W-1:0]   alu_cand;
    logic [OPND_W-1:0]         alu_plier, alu_dend, alu_quot;
    logic [DVSR_W-1:0]         alu_sor;
    logic                      alu_busy;
    logic signed [ACC_W-1:0]   alu_acc;

    lfs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign rspan    = $signed({1'b0, cfg.right_limit}) - $signed({1'b0, cfg.center_position});
    assign lspan    = $signed({1'b0, cfg.left_limit}) - $signed({1'b0, cfg.center_position});
    assign span_sel = idx_reg[IDX_W-1] ? lspan : rspan;
    assign spd_c    = sensor_speed(idx_reg);

    lfs_weight u_weight (
        .span (span_sel),
        .idx  (idx_reg),
        .term (term)
    );

    lfs_alu #(
        .ACC_W (ACC_W)
    ) u_alu (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (alu_cmd),
        .mul_cand  (alu_cand),
        .mul_plier (alu_plier),
        .div_dend  (alu_dend),
        .div_sor   (alu_sor),
        .busy      (alu_busy),
        .acc       (alu_acc),
        .quot      (alu_quot)
    );

    // A jump of more than one lit sensor, or a wide blob, counts as a glitch
    assign glitch = ({1'b0, count_reg} > ({1'b0, prev_cnt_reg} + (CNT_W+1)'(1)))
                  || (count_reg > MAX_RUN_CNT);

    assign num_run = {total_reg[WSUM_W-1], total_reg} + {prev_sum_reg[WSUM_W-1], prev_sum_reg};
    assign num     = glitch ? ((prev_cnt_reg == '0) ? '0
                                : {prev_sum_reg[WSUM_W-1], prev_sum_reg})
                            : num_run;
    assign num_abs = num[WSUM_W] ? -num : num;

    always_comb begin
        if (glitch) begin
            sor_pos = (prev_cnt_reg == '0) ? DVSR_W'(1) : DVSR_W'(prev_cnt_reg);
        end else if (count_reg != '0) begin
            sor_pos = DVSR_W'(count_reg) + DVSR_W'(prev_cnt_reg);
        end else begin
            sor_pos = POS_DIV_DARK;
        end
    end

    // speed / count / 5 equals speed / (5 * count)
    assign sor_spd = (count_reg != '0)
                   ? DVSR_W'({count_reg, 2'b00}) + DVSR_W'(count_reg)
                   : SPEED_DIV_DARK;

    assign pos_q   = neg_reg ? -$signed(alu_quot[POS_W-1:0]) : $signed(alu_quot[POS_W-1:0]);
    assign spa_sum = {1'b0, spa_reg} + {1'b0, alu_quot[DUTY_W-1:0]};

    assign isum     = {integ_reg[I_W-1], integ_reg}
                    + {{(I_W+1-POS_W){pos_reg[POS_W-1]}}, pos_reg};
    assign pos_diff = {pos_reg[POS_W-1], pos_reg} - {last_pos_reg[POS_W-1], last_pos_reg};

    // Shared unit command and operand selection
    always_comb begin
        alu_cmd   = '0;
        alu_dend  = num_abs[OPND_W-1:0];
        alu_sor   = sor_pos;
        alu_cand  = {{(ACC_W-POS_W){pos_reg[POS_W-1]}}, pos_reg};
        alu_plier = cfg.gain_p;
        case (state_reg)
            ST_DIVP_GO: begin
                alu_cmd.start = 1'b1;
                alu_cmd.op    = ALU_OP_DIV;
            end
            ST_DIVP_WAIT: begin
                alu_dend = OPND_W'(speed_reg);
                alu_sor  = sor_spd;
                if (!alu_busy && !glitch_reg) begin
                    alu_cmd.start = 1'b1;
                    alu_cmd.op    = ALU_OP_DIV;
                end
            end
            ST_INTEG: begin
                if (!edge_reg) begin
                    alu_cmd.start = 1'b1;
                    alu_cmd.op    = ALU_OP_MUL;
                    alu_cmd.clr   = 1'b1;
                end
            end
            ST_MULP: begin
                alu_cand  = {{(ACC_W-I_W){integ_reg[I_W-1]}}, integ_reg};
                alu_plier = cfg.gain_i;
                if (!alu_busy) begin
                    alu_cmd.start = 1'b1;
                    alu_cmd.op    = ALU_OP_MUL;
                end
            end
            ST_MULI: begin
                alu_cand  = {{(ACC_W-POS_W-1){pos_diff[POS_W]}}, pos_diff};
                alu_plier = cfg.gain_d;
                if (!alu_busy) begin
                    alu_cmd.start = 1'b1;
                    alu_cmd.op    = ALU_OP_MUL;
                end
            end
            default: alu_cmd = '0;
        endcase
    end

    // Correction magnitude, truncated toward zero
    assign acc_abs  = alu_acc[ACC_W-1] ? -alu_acc : alu_acc;
    assign center_w = {{(ACC_W+1-SERVO_W){1'b0}}, cfg.center_position};
    assign mag_w    = {1'b0, mag_reg};

    assign lo   = (cfg.right_limit < cfg.left_limit) ? cfg.right_limit : cfg.left_limit;
    assign hi   = (cfg.right_limit < cfg.left_limit) ? cfg.left_limit : cfg.right_limit;
    assign lo_w = $signed({{(ACC_W+1-SERVO_W){1'b0}}, lo});
    assign hi_w = $signed({{(ACC_W+1-SERVO_W){1'b0}}, hi});

    always_comb begin
        if (wide_reg < lo_w) begin
            servo_pid = lo;
        end else if (wide_reg > hi_w) begin
            servo_pid = hi;
        end else begin
            servo_pid = wide_reg[SERVO_W-1:0];
        end
    end

    assign e_sum = {pos_reg[POS_W-1], pos_reg} + {2'b00, cfg.center_position};

    always_comb begin
        if (e_sum[SPAN_W]) begin
            servo_edge = '0;
        end else if (e_sum[SPAN_W-1]) begin
            servo_edge = '1;
        end else begin
            servo_edge = e_sum[SERVO_W-1:0];
        end
    end

    assign servo = edge_reg ? servo_edge : servo_pid;
    assign brake = (last_pos_reg != '0);

    always_comb begin
        if (!brake) begin
            duty = cfg.max_speed;
        end else if (cfg.turn_speed > spa_reg) begin
            duty = cfg.turn_speed - spa_reg;
        end else begin
            duty = '0;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        bits_next       = bits_reg;
        total_next      = total_reg;
        count_next      = count_reg;
        speed_next      = speed_reg;
        edge_next       = edge_reg;
        glitch_next     = glitch_reg;
        neg_next        = neg_reg;
        pos_next        = pos_reg;
        prev_sum_next   = prev_sum_reg;
        prev_cnt_next   = prev_cnt_reg;
        prev_speed_next = prev_speed_reg;
        spa_next        = spa_reg;
        last_pos_next   = last_pos_reg;
        integ_next      = integ_reg;
        mag_next        = mag_reg;
        wide_next       = wide_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg;

        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    bits_next  = s_axis_tdata;
                    idx_next   = '0;
                    total_next = '0;
                    count_next = '0;
                    speed_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (bits_reg[idx_reg]) begin
                    count_next = count_reg + CNT_W'(1);
                    total_next = total_reg + {{(WSUM_W-SPAN_W){term[SPAN_W-1]}}, term};
                    speed_next = speed_reg + SPEED_W'(spd_c);
                end
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(SENSORS - 1)) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                // All dark: hold the previous sample's sums
                if (bits_reg == '0) begin
                    total_next = prev_sum_reg;
                    count_next = prev_cnt_reg;
                    speed_next = prev_speed_reg;
                    edge_next  = 1'b1;
                end else begin
                    edge_next  = bits_reg[0] | bits_reg[SENSORS-1];
                end
                state_next = ST_DIVP_GO;
            end
            ST_DIVP_GO: begin
                glitch_next = glitch;
                neg_next    = num[WSUM_W];
                state_next  = ST_DIVP_WAIT;
            end
            ST_DIVP_WAIT: begin
                if (!alu_busy) begin
                    pos_next   = pos_q;
                    state_next = glitch_reg ? ST_INTEG : ST_DIVS_WAIT;
                end
            end
            ST_DIVS_WAIT: begin
                if (!alu_busy) begin
                    spa_next        = spa_sum[DUTY_W:1];
                    prev_sum_next   = total_reg;
                    prev_cnt_next   = count_reg;
                    prev_speed_next = speed_reg;
                    if (count_reg > CNT_W'(1)) begin
                        edge_next = 1'b0;
                    end
                    state_next = ST_INTEG;
                end
            end
            ST_INTEG: begin
                // Saturate the integral on signed overflow
                if (isum[I_W] != isum[I_W-1]) begin
                    integ_next = isum[I_W] ? {1'b1, {(I_W-1){1'b0}}} : {1'b0, {(I_W-1){1'b1}}};
                end else begin
                    integ_next = isum[I_W-1:0];
                end
                state_next = edge_reg ? ST_FINISH : ST_MULP;
            end
            ST_MULP: begin
                if (!alu_busy) begin
                    state_next = ST_MULI;
                end
            end
            ST_MULI: begin
                if (!alu_busy) begin
                    state_next = ST_MULD;
                end
            end
            ST_MULD: begin
                if (!alu_busy) begin
                    state_next = ST_FIN_A;
                end
            end
            ST_FIN_A: begin
                neg_next   = alu_acc[ACC_W-1];
                mag_next   = acc_abs >> GAIN_FRACTION_BITS;
                state_next = ST_FIN_B;
            end
            ST_FIN_B: begin
                wide_next  = neg_reg ? $signed(center_w - mag_w) : $signed(center_w + mag_w);
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // Hold until the result register is free
                if (!m_valid_reg || m_axis_tready) begin
                    m_data_next   = {{MPAD_W{1'b0}}, pos_reg, edge_reg, brake, duty, servo};
                    m_valid_next  = 1'b1;
                    last_pos_next = pos_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            prev_sum_reg   <= '0;
            prev_cnt_reg   <= '0;
            prev_speed_reg <= '0;
            spa_reg        <= '0;
            last_pos_reg   <= '0;
            integ_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            prev_sum_reg   <= prev_sum_next;
            prev_cnt_reg   <= prev_cnt_next;
            prev_speed_reg <= prev_speed_next;
            spa_reg        <= spa_next;
            last_pos_reg   <= last_pos_next;
            integ_reg      <= integ_next;
        end
        idx_reg    <= idx_next;
        bits_reg   <= bits_next;
        total_reg  <= total_next;
        count_reg  <= count_next;
        speed_reg  <= speed_next;
        edge_reg   <= edge_next;
        glitch_reg <= glitch_next;
        neg_reg    <= neg_next;
        pos_reg    <= pos_next;
        mag_reg    <= mag_next;
        wide_reg   <= wide_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
